// ===== rtl/ffha_pkg.sv =====
// shared types and constants for the first-fit heap allocator
package ffha_pkg;

   localparam int HEAP_WORDS_DEF  = 4096;
   localparam int HEADER_WORDS    = 3;
   localparam int MIN_SPLIT_DEF   = 1;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FAIL     = 2'd1;
   localparam logic [1:0] ST_BAD_FREE = 2'd2;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // classified request handed from front to back
   typedef struct packed {
      logic        is_free;
      logic        is_null;    // result known without touching the heap
      logic [1:0]  null_status;
      logic [15:0] words;      // allocation size in words
      logic [31:0] off_words;  // free: word offset of data from base
   } cmd_type;

endpackage

// ===== rtl/first_fit_coalescing_heap_allocator_unit.sv =====
// top level of the first-fit coalescing heap allocator
//
//  channel | dir | handshake          | payload
//  req     | in  | tvalid/tready      | tuser: action; tdata: size_bytes, data_addr_in
//  rsp     | out | tvalid/tready      | tdata: data_addr, status, heap_top_addr
//  csr     | in  | wen                | wdata: heap_base
//
// an allocate walks the free list node by node, then writes the headers
// a free walks the block chain and the free list
// then links and merges, all set by one header read per cycle
// reset clears heap top and free list; header memory is not cleared
// a two-entry queue lets requests be taken while the engine works or output stalls
module first_fit_coalescing_heap_allocator_unit #(
   parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
   parameter int MIN_SPLIT  = ffha_pkg::MIN_SPLIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // action
   input  logic [47:0] req_tdata,   // size_bytes[15:0], data_addr_in[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // data_addr[31:0], status[1:0], heap_top_addr[31:0], pad
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata
);
   logic [31:0] heap_base_ff;
   logic [31:0] base;
   logic        cmd_valid, cmd_ready;
   ffha_pkg::cmd_type cmd;
   logic [31:0] data_addr, top_addr;
   logic [1:0]  status;

   always_ff @(posedge clock) begin
      if (reset) heap_base_ff <= 32'd32;
      else if (csr_wen) heap_base_ff <= csr_wdata;
   end
   // low three bits ignored
   assign base = {heap_base_ff[31:3], 3'b000};

   ffha_front u_front (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_tuser, .req_tdata, .base,
      .cmd_valid, .cmd_ready, .cmd
   );

   ffha_back #(.HEAP_WORDS(HEAP_WORDS), .MIN_SPLIT(MIN_SPLIT)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd, .base,
      .rsp_tvalid, .rsp_tready,
      .rsp_data_addr(data_addr), .rsp_status(status), .rsp_top(top_addr)
   );

   assign rsp_tdata = {6'd0, top_addr, status, data_addr};
endmodule

// ===== rtl/ffha_front.sv =====
// request intake: decodes and classifies each request into a command
module ffha_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,
   input  logic [47:0]         req_tdata,
   input  logic [31:0]         base,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output ffha_pkg::cmd_type   cmd
);
   logic        action;
   logic [15:0] size_bytes;
   logic [31:0] addr_in;
   logic [31:0] off;
   logic [16:0] words_wide;
   ffha_pkg::cmd_type cmd_in;

   assign action     = req_tuser;
   assign size_bytes = req_tdata[15:0];
   assign addr_in    = req_tdata[47:16];
   assign off        = addr_in - base;
   assign words_wide = ({1'b0, size_bytes} + 17'd7) >> 3;

   always_comb begin
      cmd_in             = '0;
      cmd_in.is_free     = (action == ffha_pkg::ACT_FREE);
      cmd_in.words       = words_wide[15:0];
      cmd_in.off_words   = {3'b000, off[31:3]};
      cmd_in.null_status = ffha_pkg::ST_OK;
      if (action == ffha_pkg::ACT_ALLOC) begin
         if (size_bytes == 16'd0) begin
            cmd_in.is_null     = 1'b1;
            cmd_in.null_status = ffha_pkg::ST_FAIL;
         end
      end else if (addr_in == 32'd0) begin
         cmd_in.is_null = 1'b1;
      end else if (off[2:0] != 3'd0) begin
         cmd_in.is_null     = 1'b1;
         cmd_in.null_status = ffha_pkg::ST_BAD_FREE;
      end
   end

   // small fifo between the two halves
   ffha_pkg::cmd_type q_ff [ffha_pkg::QUEUE_DEPTH];
   logic [$clog2(ffha_pkg::QUEUE_DEPTH)-1:0] wp_ff, rp_ff;
   logic [$clog2(ffha_pkg::QUEUE_DEPTH):0]   cnt_ff;
   logic push, pop;

   assign req_tready = (cnt_ff != ($clog2(ffha_pkg::QUEUE_DEPTH)+1)'(ffha_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != '0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cmd_in;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + {{$clog2(ffha_pkg::QUEUE_DEPTH){1'b0}}, push}
                          - {{$clog2(ffha_pkg::QUEUE_DEPTH){1'b0}}, pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ($clog2(ffha_pkg::QUEUE_DEPTH)+1)'(ffha_pkg::QUEUE_DEPTH))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wp_ff == rp_ff))
      else $error("queue pointers disagree with empty count");
endmodule

// ===== rtl/ffha_back.sv =====
// execution engine: walks the header memory to allocate and free blocks
module ffha_back #(
   parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
   parameter int MIN_SPLIT  = ffha_pkg::MIN_SPLIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  ffha_pkg::cmd_type cmd,
   input  logic [31:0]       base,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_data_addr,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_top
);
   localparam int IW = $clog2(HEAP_WORDS) + 1; // index width, holds HEAP_WORDS
   localparam int AW = $clog2(HEAP_WORDS);
   localparam logic [IW-1:0] HDR  = IW'(ffha_pkg::HEADER_WORDS);
   localparam logic [IW-1:0] HW   = IW'(HEAP_WORDS);
   localparam logic [IW-1:0] SPLT = IW'(ffha_pkg::HEADER_WORDS + MIN_SPLIT);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_ARD0   = 5'd1;   // read size of curr
   localparam logic [4:0] S_ARD1   = 5'd2;   // read next of curr
   localparam logic [4:0] S_AEVAL  = 5'd3;
   localparam logic [4:0] S_AW0    = 5'd4;   // split / unlink writes
   localparam logic [4:0] S_AW1    = 5'd5;
   localparam logic [4:0] S_AW2    = 5'd6;
   localparam logic [4:0] S_AW3    = 5'd7;
   localparam logic [4:0] S_AW4    = 5'd8;
   localparam logic [4:0] S_AW5    = 5'd9;
   localparam logic [4:0] S_TOP    = 5'd10;
   localparam logic [4:0] S_FCH    = 5'd11;  // chain walk read
   localparam logic [4:0] S_FCHW   = 5'd12;
   localparam logic [4:0] S_FFLG   = 5'd13;
   localparam logic [4:0] S_FFLGW  = 5'd14;
   localparam logic [4:0] S_FLST   = 5'd15;  // list walk read next
   localparam logic [4:0] S_FLSTW  = 5'd16;
   localparam logic [4:0] S_FLINK  = 5'd17;
   localparam logic [4:0] S_FC0    = 5'd18;  // read size blk
   localparam logic [4:0] S_FC1    = 5'd19;  // read size curr
   localparam logic [4:0] S_FC2    = 5'd20;  // read next curr
   localparam logic [4:0] S_FC3    = 5'd21;
   localparam logic [4:0] S_FP0    = 5'd22;  // read size prev
   localparam logic [4:0] S_FP1    = 5'd23;
   localparam logic [4:0] S_DONE   = 5'd24;
   localparam logic [4:0] S_FWAIT  = 5'd25;

   logic [15:0] mem [HEAP_WORDS];
   logic [15:0] rd_ff;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [15:0]   wdata;

   logic [4:0]    state_ff, state_in;
   logic [IW-1:0] top_ff, top_in, head_ff, head_in;
   logic          ne_ff, ne_in;
   logic [IW-1:0] curr_ff, curr_in, prev_ff, prev_in, blk_ff, blk_in;
   logic          hp_ff, hp_in, hc_ff, hc_in;
   logic [IW-1:0] csz_ff, csz_in, cnx_ff, cnx_in, bsz_ff, bsz_in;
   logic [15:0]   words_ff, words_in;
   logic [31:0]   oa_ff, oa_in;
   logic [1:0]    os_ff, os_in;
   logic          ov_ff, ov_in;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   function automatic logic [31:0] waddr32(input logic [31:0] b, input logic [IW-1:0] i);
      waddr32 = b + 32'({i, 3'b000});
   endfunction

   logic [IW+16:0] total;
   assign total = {17'd0, top_ff} + {{IW{1'b0}}, 1'b0, words_ff} + {17'd0, HDR};

   assign cmd_ready     = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid    = ov_ff;
   assign rsp_data_addr = oa_ff;
   assign rsp_status    = os_ff;
   assign rsp_top       = waddr32(base, top_ff);

   always_comb begin
      state_in = state_ff; top_in = top_ff; head_in = head_ff; ne_in = ne_ff;
      curr_in = curr_ff; prev_in = prev_ff; blk_in = blk_ff; hp_in = hp_ff; hc_in = hc_ff;
      csz_in = csz_ff; cnx_in = cnx_ff; bsz_in = bsz_ff; words_in = words_ff;
      oa_in = oa_ff; os_in = os_ff; ov_in = ov_ff;
      we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !ov_ff) begin
               words_in = cmd.words;
               oa_in = '0; os_in = cmd.null_status;
               curr_in = head_ff; hp_in = 1'b0; prev_in = '0;
               if (cmd.is_null) begin
                  ov_in = 1'b1;
               end else if (cmd.is_free) begin
                  if (cmd.off_words < 32'(ffha_pkg::HEADER_WORDS) ||
                      (cmd.off_words - 32'(ffha_pkg::HEADER_WORDS)) >= 32'(top_ff)) begin
                     os_in = ffha_pkg::ST_BAD_FREE; ov_in = 1'b1;
                  end else begin
                     blk_in = IW'(cmd.off_words - 32'(ffha_pkg::HEADER_WORDS));
                     curr_in = '0;
                     state_in = S_FCH;
                  end
               end else begin
                  state_in = ne_ff ? S_ARD0 : S_TOP;
               end
            end
         end
         // allocation walk
         S_ARD0: begin raddr = curr_ff[AW-1:0]; state_in = S_ARD1; end
         S_ARD1: begin
            raddr = AW'(curr_ff + 2'd2); csz_in = IW'(rd_ff); state_in = S_AEVAL;
         end
         S_AEVAL: begin
            cnx_in = IW'(rd_ff);
            if (32'(csz_ff) >= 32'(words_ff)) begin
               state_in = S_AW0;
            end else if (rd_ff == '0 || IW'(rd_ff) <= curr_ff) begin
               state_in = S_TOP;
            end else begin
               prev_in = curr_ff; hp_in = 1'b1; curr_in = IW'(rd_ff); state_in = S_ARD0;
            end
         end
         S_AW0: begin
            if (32'(csz_ff) >= 32'(words_ff) + 32'(SPLT)) begin
               blk_in = curr_ff + HDR + IW'(words_ff); // split point
               we = 1'b1; waddr = AW'(curr_ff + HDR + IW'(words_ff));
               wdata = 16'(csz_ff - IW'(words_ff) - HDR);
               state_in = S_AW1;
            end else begin
               if (hp_ff) begin
                  we = 1'b1; waddr = AW'(prev_ff + 2'd2); wdata = 16'(cnx_ff);
               end else begin
                  head_in = cnx_ff; ne_in = (cnx_ff != '0);
               end
               state_in = S_AW4;
            end
         end
         S_AW1: begin we = 1'b1; waddr = AW'(blk_ff + 1'b1); wdata = 16'd1; state_in = S_AW2; end
         S_AW2: begin we = 1'b1; waddr = AW'(blk_ff + 2'd2); wdata = 16'(cnx_ff); state_in = S_AW3; end
         S_AW3: begin
            if (hp_ff) begin
               we = 1'b1; waddr = AW'(prev_ff + 2'd2); wdata = 16'(blk_ff);
            end else begin
               head_in = blk_ff; ne_in = 1'b1;
            end
            state_in = S_AW5;
         end
         S_AW5: begin
            we = 1'b1; waddr = curr_ff[AW-1:0]; wdata = words_ff; state_in = S_AW4;
         end
         S_AW4: begin
            we = 1'b1; waddr = AW'(curr_ff + 1'b1); wdata = 16'd0;
            blk_in = curr_ff; state_in = S_DONE;
         end
         S_DONE: begin
            we = 1'b1; waddr = AW'(blk_ff + 2'd2); wdata = 16'd0;
            oa_in = waddr32(base, blk_ff + HDR); os_in = ffha_pkg::ST_OK;
            ov_in = 1'b1; state_in = S_IDLE;
         end
         S_TOP: begin
            if (top_ff > HW || total > (IW+17)'(HEAP_WORDS)) begin
               oa_in = '0; os_in = ffha_pkg::ST_FAIL; ov_in = 1'b1; state_in = S_IDLE;
            end else begin
               curr_in = top_ff; top_in = IW'(total);
               state_in = S_AW5;
            end
         end
         // free: confirm blk is on the block chain
         S_FCH: begin
            if (curr_ff == blk_ff) begin
               raddr = AW'(blk_ff + 1'b1); state_in = S_FFLG;
            end else if (curr_ff >= top_ff) begin
               os_in = ffha_pkg::ST_BAD_FREE; ov_in = 1'b1; state_in = S_IDLE;
            end else begin
               raddr = curr_ff[AW-1:0]; state_in = S_FCHW;
            end
         end
         S_FCHW: begin curr_in = curr_ff + HDR + IW'(rd_ff); state_in = S_FCH; end
         // keep the flag address so the read data is still there next cycle
         S_FFLG: begin raddr = AW'(blk_ff + 1'b1); state_in = S_FFLGW; end
         S_FFLGW: begin
            if (rd_ff != '0) begin
               os_in = ffha_pkg::ST_BAD_FREE; ov_in = 1'b1; state_in = S_IDLE;
            end else begin
               we = 1'b1; waddr = AW'(blk_ff + 1'b1); wdata = 16'd1;
               curr_in = head_ff; hc_in = ne_ff; hp_in = 1'b0; prev_in = '0;
               state_in = S_FLST;
            end
         end
         S_FLST: begin
            if (hc_ff && curr_ff < blk_ff) begin
               raddr = AW'(curr_ff + 2'd2); state_in = S_FLSTW;
            end else begin
               state_in = S_FLINK;
            end
         end
         S_FLSTW: begin
            prev_in = curr_ff; hp_in = 1'b1;
            hc_in = (rd_ff != '0) && (IW'(rd_ff) > curr_ff);
            curr_in = ((rd_ff != '0) && (IW'(rd_ff) > curr_ff)) ? IW'(rd_ff) : '0;
            state_in = S_FLST;
         end
         S_FLINK: begin
            we = 1'b1; waddr = AW'(blk_ff + 2'd2); wdata = hc_ff ? 16'(curr_ff) : 16'd0;
            cnx_in = hc_ff ? curr_ff : '0;
            if (!hp_ff) begin head_in = blk_ff; ne_in = 1'b1; end
            state_in = S_FC0;
         end
         S_FC0: begin
            if (hp_ff) begin we = 1'b1; waddr = AW'(prev_ff + 2'd2); wdata = 16'(blk_ff); end
            raddr = blk_ff[AW-1:0]; state_in = S_FC1;
         end
         S_FC1: begin
            bsz_in = IW'(rd_ff); raddr = curr_ff[AW-1:0]; state_in = S_FC2;
         end
         S_FC2: begin
            csz_in = IW'(rd_ff); raddr = AW'(curr_ff + 2'd2); state_in = S_FC3;
         end
         S_FC3: begin
            if (hc_ff && (blk_ff + HDR + bsz_ff == curr_ff)) begin
               bsz_in = bsz_ff + HDR + csz_ff; cnx_in = IW'(rd_ff);
               we = 1'b1; waddr = blk_ff[AW-1:0]; wdata = 16'(bsz_ff + HDR + csz_ff);
               state_in = S_FWAIT;
            end else begin
               state_in = S_FP0;
            end
         end
         S_FWAIT: begin
            we = 1'b1; waddr = AW'(blk_ff + 2'd2); wdata = 16'(cnx_ff); state_in = S_FP0;
         end
         S_FP0: begin raddr = prev_ff[AW-1:0]; state_in = S_FP1; end
         S_FP1: begin
            if (hp_ff && (prev_ff + HDR + IW'(rd_ff) == blk_ff)) begin
               we = 1'b1; waddr = prev_ff[AW-1:0]; wdata = 16'(IW'(rd_ff) + HDR + bsz_ff);
               blk_in = prev_ff;   // then link prev to blk's next
               state_in = S_FWAIT;
               hp_in = 1'b0;
            end else begin
               os_in = ffha_pkg::ST_OK; oa_in = '0; ov_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      curr_ff <= curr_in; prev_ff <= prev_in; blk_ff <= blk_in; hc_ff <= hc_in;
      csz_ff <= csz_in; cnx_ff <= cnx_in; bsz_ff <= bsz_in; words_ff <= words_in;
      oa_ff <= oa_in; os_ff <= os_in; hp_ff <= hp_in;
      if (reset) begin
         state_ff <= S_IDLE; top_ff <= '0; head_ff <= '0; ne_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; top_ff <= top_in; head_ff <= head_in;
         ne_ff <= ne_in; ov_ff <= ov_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) top_ff <= HW)
      else $error("heap top beyond heap");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !cmd_ready)
      else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp_tready) |=> ov_ff && $stable(oa_ff))
      else $error("result lost under stall");
endmodule
